/* rtl/cws_pkg.sv */
// Package: shared types and character/code constants for the command line word splitter.
package cws_pkg;

  // Special characters.
  localparam logic [15:0] CH_DQUOTE = 16'h0022;
  localparam logic [15:0] CH_SQUOTE = 16'h0027;
  localparam logic [15:0] CH_BSLASH = 16'h005C;
  localparam logic [15:0] CH_SPACE  = 16'h0020;

  // Input action codes.
  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Result event codes.
  localparam logic EV_APPEND = 1'b0;
  localparam logic EV_DONE   = 1'b1;

  // Rule modes.
  localparam logic MODE_WIN  = 1'b0;
  localparam logic MODE_BASH = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] char_code;
  } cws_item_t;

  typedef struct packed {
    logic        event_kind;
    logic [15:0] char_out;
    logic        was_quoted;
  } cws_result_t;

  typedef struct packed {
    logic in_double_quotes;
    logic in_single_quotes;
    logic quote_just_closed;
    logic escape_pending;
    logic argument_nonempty;
  } cws_flags_t;

  // Handshake between the input register and the lexer.
  typedef struct packed {
    logic      step;   // item moves from input register into the lexer
    cws_item_t item;
  } cws_step_t;

endpackage

/* rtl/cws_if.sv */
// Interfaces: valid/ready word channels for input items and result items.
interface cws_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] char_code;

  modport source (output valid, output action, output char_code, input ready);
  modport sink   (input valid, input action, input char_code, output ready);
endinterface

interface cws_out_if;
  logic        valid;
  logic        ready;
  logic        event_kind;
  logic [15:0] char_out;
  logic        was_quoted;

  modport source (output valid, output event_kind, output char_out, output was_quoted,
                  input ready);
  modport sink   (input valid, input event_kind, input char_out, input was_quoted,
                  output ready);
endinterface

/* rtl/cws_in_stage.sv */
// Input register: holds one accepted word until the lexer takes it.
module cws_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  cws_pkg::cws_item_t in_item,
  input  logic             slot_free,
  output cws_pkg::cws_step_t step
);
  import cws_pkg::*;

  logic      valid_r, valid_nxt;
  cws_item_t item_r;
  logic      advance;

  assign advance  = valid_r && slot_free;
  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign step.step = advance;
  assign step.item = item_r;

endmodule

/* rtl/cws_lexer.sv */
// Lexer: quoting flags and the per-word split decision.
module cws_lexer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rule_mode,
  input  cws_pkg::cws_step_t   step,
  output logic                 emit,
  output cws_pkg::cws_result_t res
);
  import cws_pkg::*;

  cws_flags_t flags_r, flags_nxt;
  logic [15:0] c;

  assign c = step.item.char_code;

  always_comb begin
    flags_nxt = flags_r;
    emit      = 1'b0;
    res       = '0;
    if (step.item.action == ACT_END) begin
      if (flags_r.argument_nonempty) begin
        emit           = 1'b1;
        res.event_kind = EV_DONE;
        res.was_quoted = flags_r.in_double_quotes || flags_r.quote_just_closed ||
                         ((rule_mode == MODE_BASH) && flags_r.in_single_quotes);
      end
      flags_nxt = '0;
    end else if (rule_mode == MODE_WIN) begin
      if (flags_r.in_double_quotes) begin
        if (c == CH_DQUOTE) begin
          flags_nxt.in_double_quotes  = 1'b0;
          flags_nxt.quote_just_closed = 1'b1;
        end else begin
          emit = 1'b1;
          res.char_out = c;
          flags_nxt.argument_nonempty = 1'b1;
        end
      end else begin
        if (c == CH_DQUOTE) begin
          flags_nxt.in_double_quotes = 1'b1;
          if (flags_r.quote_just_closed) begin
            // quote after a closing quote: literal quote
            emit = 1'b1;
            res.char_out = CH_DQUOTE;
            flags_nxt.argument_nonempty = 1'b1;
          end
        end else if (c == CH_SPACE) begin
          if (flags_r.argument_nonempty || flags_r.quote_just_closed) begin
            emit           = 1'b1;
            res.event_kind = EV_DONE;
            res.was_quoted = flags_r.quote_just_closed;
            flags_nxt.argument_nonempty = 1'b0;
          end
        end else begin
          emit = 1'b1;
          res.char_out = c;
          flags_nxt.argument_nonempty = 1'b1;
        end
        flags_nxt.quote_just_closed = 1'b0;
      end
    end else begin
      if (flags_r.in_single_quotes) begin
        if (c == CH_SQUOTE) begin
          flags_nxt.in_single_quotes  = 1'b0;
          flags_nxt.quote_just_closed = 1'b1;
        end else begin
          emit = 1'b1;
          res.char_out = c;
          flags_nxt.argument_nonempty = 1'b1;
        end
      end else if (flags_r.escape_pending) begin
        flags_nxt.escape_pending = 1'b0;
        emit = 1'b1;
        res.char_out = c;
        flags_nxt.argument_nonempty = 1'b1;
      end else if (flags_r.in_double_quotes) begin
        if (c == CH_BSLASH) begin
          flags_nxt.escape_pending = 1'b1;
        end else if (c == CH_DQUOTE) begin
          flags_nxt.in_double_quotes  = 1'b0;
          flags_nxt.quote_just_closed = 1'b1;
        end else begin
          emit = 1'b1;
          res.char_out = c;
          flags_nxt.argument_nonempty = 1'b1;
        end
      end else begin
        if (c == CH_BSLASH) begin
          flags_nxt.escape_pending = 1'b1;
        end else if (c == CH_SQUOTE) begin
          flags_nxt.in_single_quotes = 1'b1;
        end else if (c == CH_DQUOTE) begin
          flags_nxt.in_double_quotes = 1'b1;
        end else if (c == CH_SPACE) begin
          if (flags_r.argument_nonempty || flags_r.quote_just_closed) begin
            emit           = 1'b1;
            res.event_kind = EV_DONE;
            res.was_quoted = flags_r.quote_just_closed;
            flags_nxt.argument_nonempty = 1'b0;
          end
        end else begin
          emit = 1'b1;
          res.char_out = c;
          flags_nxt.argument_nonempty = 1'b1;
        end
        flags_nxt.quote_just_closed = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (step.step) begin
      flags_r <= flags_nxt;
    end
  end

  // An end word leaves every flag clear.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step.step && (step.item.action == ACT_END) |=> (flags_r == '0))
    else $error("flags not cleared after end word");

  // A completion carries no character; an append carries no quoted flag.
  a_done_zero_char: assert property (@(posedge clk) disable iff (!rst_n)
    emit && (res.event_kind == EV_DONE) |-> (res.char_out == '0))
    else $error("completion with nonzero character");

  a_append_unquoted: assert property (@(posedge clk) disable iff (!rst_n)
    emit && (res.event_kind == EV_APPEND) |-> !res.was_quoted)
    else $error("append with quoted flag");

  // An appended character always leaves the argument marked nonempty.
  a_append_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    step.step && emit && (res.event_kind == EV_APPEND) |=> flags_r.argument_nonempty)
    else $error("append did not mark argument nonempty");

endmodule

/* rtl/cws_out_stage.sv */
// Result register: holds one result word until the sink takes it.
module cws_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  cws_pkg::cws_result_t res,
  output logic                 slot_free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cws_pkg::cws_result_t out_res
);
  import cws_pkg::*;

  logic        valid_r, valid_nxt;
  cws_result_t res_r;

  assign slot_free = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

/* rtl/command_line_word_splitter.sv */
// Top level: command line word splitter, one 16-bit character word per cycle while out_word does not stall.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+-----------------------------------
//   in_word  | in  | valid/ready          | action, char_code
//   out_word | out | valid/ready          | event_kind, char_out, was_quoted
//   cfg      | in  | cfg_we (no ready)    | cfg_wdata = rule_mode
//
// Throughput is one word per cycle while the result register is not stalled. An accepted word loads
// the input register, then the lexer flags and the result register as it advances out of it.
// Reset is synchronous on rst_n low: clears valids and quoting flags, rule_mode to bash.
// A stalled result register holds the lexer, which holds the input register; in_ready
// drops only when both registers are full and out_ready is low.
// Words that cause no result (quote marks, escapes, leading spaces) still pass through the input register.
module command_line_word_splitter (
  input  logic      clk,
  input  logic      rst_n,
  cws_in_if.sink    in_word,
  cws_out_if.source out_word,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);
  import cws_pkg::*;

  logic        rule_mode_r;
  cws_item_t   in_item;
  cws_step_t   step;
  logic        slot_free;
  logic        emit;
  cws_result_t res;
  cws_result_t out_res;

  // Mode register; the user must see that it is written only while the block is idle; not enforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_mode_r <= MODE_BASH;
    end else if (cfg_we) begin
      rule_mode_r <= cfg_wdata;
    end
  end

  assign in_item.action    = in_word.action;
  assign in_item.char_code = in_word.char_code;

  // Hold the accepted word until the result slot can take its outcome.
  cws_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_word.valid),
    .in_ready (in_word.ready),
    .in_item  (in_item),
    .slot_free(slot_free),
    .step     (step)
  );

  // Advance the quoting flags and decide the result for this word.
  cws_lexer u_lex (
    .clk      (clk),
    .rst_n    (rst_n),
    .rule_mode(rule_mode_r),
    .step     (step),
    .emit     (emit),
    .res      (res)
  );

  // Load a result only when the word really produces one.
  cws_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (step.step && emit),
    .res      (res),
    .slot_free(slot_free),
    .out_valid(out_word.valid),
    .out_ready(out_word.ready),
    .out_res  (out_res)
  );

  assign out_word.event_kind = out_res.event_kind;
  assign out_word.char_out   = out_res.char_out;
  assign out_word.was_quoted = out_res.was_quoted;

endmodule
